>>> sv/cvpe_pkg.sv
`timescale 1ns / 1ps
// Package of the pose extrapolator: beat types, register codes and shared constants.
package cvpe_pkg;

	// Input beat: one tracked object.
	typedef struct packed {
		logic [15:0]        object_tag;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic [15:0]        box_length_mm;
		logic               skip_prediction;
	} obj_in_t;

	// Output beat: one predicted pose, or a marker for an object with no pose.
	typedef struct packed {
		logic [15:0]        result_tag;
		logic [6:0]         step_index;
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [31:0] pose_z;
		logic               has_pose;
		logic               last_of_object;
	} pose_out_t;

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		logic [9:0]  step_ms;
		logic [13:0] horizon_ms;
		logic [15:0] length_threshold_mm;
		logic [15:0] speed_large_mm_s;
		logic [15:0] speed_small_mm_s;
	} cfg_t;

	// Classified object handed from the front end to the pose generator.
	// stc and sts are speed times cos and sin of the heading.
	typedef struct packed {
		logic [15:0]        tag;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] stc;
		logic signed [31:0] sts;
		logic               no_pose;
	} obj_t;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_STEP_MS    = 3'd0,
		REG_HORIZON_MS = 3'd1,
		REG_LEN_THRESH = 3'd2,
		REG_SPEED_LRG  = 3'd3,
		REG_SPEED_SML  = 3'd4
	} cfg_reg_t;

	localparam logic [9:0]  STEP_RST    = 10'd200;
	localparam logic [13:0] HORIZON_RST = 14'd3000;
	localparam logic [15:0] THRESH_RST  = 16'd3500;
	localparam logic [15:0] SPD_LRG_RST = 16'd5000;
	localparam logic [15:0] SPD_SML_RST = 16'd1400;

	// CORDIC gain compensation in Q2.30.
	localparam logic [31:0] GAIN_Q30 = 32'd652032874;

	// Offset divisor 32768000 = 2^18 * 125, rounding half added before the shift.
	localparam logic [46:0] ROUND_HALF  = 47'd16384000;
	localparam int          DIV_SHIFT   = 18;
	localparam logic [30:0] DIV_RECIP   = 31'd1099511628;
	localparam int          RECIP_SHIFT = 37;
	localparam logic [6:0]  DIV_ODD     = 7'd125;

	// A zero step behaves as one millisecond.
	function automatic logic [9:0] eff_step(input cfg_t c);
		eff_step = (c.step_ms == 10'd0) ? 10'd1 : c.step_ms;
	endfunction

endpackage

>>> sv/cvpe_front.sv
`timescale 1ns / 1ps
// Front end: heading products, pipelined CORDIC, rounding and speed scaling.
module cvpe_front
	import cvpe_pkg::*;
#(
	parameter int unsigned CORDIC_ITERATIONS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_ready,
	input  obj_in_t in_data,
	output logic    push_valid,
	input  logic    push_ready,
	output obj_t    push_data
);

	localparam int N  = CORDIC_ITERATIONS;
	localparam int VW = 36;
	localparam int CW = 34;

	typedef struct packed {
		logic [15:0]        tag;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0]        speed;
		logic               no_pose;
		logic               zero;
		logic               flip;
	} meta_t;

	function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		r = (v + $signed(CW'(16384))) >>> 15;
		if (r > $signed(CW'(32767))) begin
			to_q15 = 16'sh7FFF;
		end else if (r < -$signed(CW'(32768))) begin
			to_q15 = 16'sh8000;
		end else begin
			to_q15 = r[15:0];
		end
	endfunction

	logic en;

	logic               vld_s1;
	logic signed [31:0] wz_s1, xy_s1, yy_s1, zz_s1;
	meta_t              meta_s1;

	logic                 cvld_s [0:N];
	logic signed [VW-1:0] vx_s   [0:N];
	logic signed [VW-1:0] vy_s   [0:N];
	logic signed [CW-1:0] cx_s   [0:N];
	logic signed [CW-1:0] cy_s   [0:N];
	meta_t                meta_s [0:N];

	logic               vld_s3;
	logic signed [15:0] cos_s3, sin_s3;
	meta_t              meta_s3;

	logic               vld_s4;
	logic signed [31:0] stc_s4, sts_s4;
	meta_t              meta_s4;

	// The whole pipeline advances unless a finished object cannot enter the queue.
	assign en         = !vld_s4 || push_ready;
	assign in_ready   = en;
	assign push_valid = vld_s4;

	// Stage 1: quaternion products, speed choice and classification.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wz_s1 <= in_data.quat_w * in_data.quat_z;
			xy_s1 <= in_data.quat_x * in_data.quat_y;
			yy_s1 <= in_data.quat_y * in_data.quat_y;
			zz_s1 <= in_data.quat_z * in_data.quat_z;
			meta_s1.tag     <= in_data.object_tag;
			meta_s1.pos_x   <= in_data.pos_x;
			meta_s1.pos_y   <= in_data.pos_y;
			meta_s1.pos_z   <= in_data.pos_z;
			meta_s1.speed   <= (in_data.box_length_mm > cfg.length_threshold_mm) ?
				cfg.speed_large_mm_s : cfg.speed_small_mm_s;
			meta_s1.no_pose <= in_data.skip_prediction ||
				({4'd0, eff_step(cfg)} > cfg.horizon_ms);
			meta_s1.zero    <= 1'b0;
			meta_s1.flip    <= 1'b0;
		end
	end

	// Stage 2: yaw vector in Q2.30, folded into the right half plane.
	logic signed [34:0] num_c, den_c;
	logic               zero_c, flip_c;
	meta_t              meta_c;

	always_comb begin
		num_c  = 35'(($signed({wz_s1[31], wz_s1}) + $signed({xy_s1[31], xy_s1})) <<< 1);
		den_c  = $signed(35'(1 << 30)) -
			35'(($signed({yy_s1[31], yy_s1}) + $signed({zz_s1[31], zz_s1})) <<< 1);
		zero_c = (num_c == 35'sd0) && (den_c == 35'sd0);
		flip_c = den_c[34];
		meta_c = meta_s1;
		meta_c.zero = zero_c;
		meta_c.flip = flip_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_s[0] <= 1'b0;
		end else if (en) begin
			cvld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s[0]   <= flip_c ? -VW'(den_c) : VW'(den_c);
			vy_s[0]   <= flip_c ? -VW'(num_c) : VW'(num_c);
			cx_s[0]   <= $signed(CW'(GAIN_Q30));
			cy_s[0]   <= '0;
			meta_s[0] <= meta_c;
		end
	end

	// One CORDIC vectoring iteration per stage; the gain vector follows the same turns.
	for (genvar gi = 1; gi <= N; gi++) begin : g_iter
		localparam int SH = gi - 1;
		logic signed [VW-1:0] vx_sh, vy_sh;
		logic signed [CW-1:0] cx_sh, cy_sh;
		logic                 dir;

		assign vx_sh = vx_s[gi-1] >>> SH;
		assign vy_sh = vy_s[gi-1] >>> SH;
		assign cx_sh = cx_s[gi-1] >>> SH;
		assign cy_sh = cy_s[gi-1] >>> SH;
		assign dir   = !vy_s[gi-1][VW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cvld_s[gi] <= 1'b0;
			end else if (en) begin
				cvld_s[gi] <= cvld_s[gi-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (dir) begin
					vx_s[gi] <= vx_s[gi-1] + vy_sh;
					vy_s[gi] <= vy_s[gi-1] - vx_sh;
					cx_s[gi] <= cx_s[gi-1] - cy_sh;
					cy_s[gi] <= cy_s[gi-1] + cx_sh;
				end else begin
					vx_s[gi] <= vx_s[gi-1] - vy_sh;
					vy_s[gi] <= vy_s[gi-1] + vx_sh;
					cx_s[gi] <= cx_s[gi-1] + cy_sh;
					cy_s[gi] <= cy_s[gi-1] - cx_sh;
				end
				meta_s[gi] <= meta_s[gi-1];
			end
		end
	end

	// Stage 3: undo the fold, round to Q1.15, handle the degenerate quaternion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= cvld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (meta_s[N].zero) begin
				cos_s3 <= 16'sh7FFF;
				sin_s3 <= '0;
			end else if (meta_s[N].flip) begin
				cos_s3 <= to_q15(-cx_s[N]);
				sin_s3 <= to_q15(-cy_s[N]);
			end else begin
				cos_s3 <= to_q15(cx_s[N]);
				sin_s3 <= to_q15(cy_s[N]);
			end
			meta_s3 <= meta_s[N];
		end
	end

	// Stage 4: scale heading by the chosen speed.
	logic signed [32:0] stc_c, sts_c;

	assign stc_c = $signed({1'b0, meta_s3.speed}) * cos_s3;
	assign sts_c = $signed({1'b0, meta_s3.speed}) * sin_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stc_s4  <= stc_c[31:0];
			sts_s4  <= sts_c[31:0];
			meta_s4 <= meta_s3;
		end
	end

	always_comb begin
		push_data.tag     = meta_s4.tag;
		push_data.pos_x   = meta_s4.pos_x;
		push_data.pos_y   = meta_s4.pos_y;
		push_data.pos_z   = meta_s4.pos_z;
		push_data.stc     = stc_s4;
		push_data.sts     = sts_s4;
		push_data.no_pose = meta_s4.no_pose;
	end

endmodule

>>> sv/cvpe_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue of classified objects between the front end and the pose generator.
module cvpe_fifo
	import cvpe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  obj_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output obj_t pop_data
);

	obj_t       mem_q [0:1];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_ptr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q)) else $error("pointers disagree with count");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("push lost");
`endif

endmodule

>>> sv/cvpe_back.sv
`timescale 1ns / 1ps
// Pose generator: steps prediction times, one saturated pose per cycle unless stalled.
module cvpe_back
	import cvpe_pkg::*;
#(
	parameter int unsigned MAX_POSES = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  obj_t      pop_data,
	output logic      out_valid,
	input  logic      out_ready,
	output pose_out_t out_data
);

	typedef struct packed {
		logic [15:0]        tag;
		logic [6:0]         k;
		logic               has;
		logic               last;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} carry_t;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			sat32 = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	logic en;

	// Sequencer state for the object being expanded.
	logic        act_q;
	obj_t        obj_q;
	logic [6:0]  k_q;
	logic [13:0] t_q;

	logic [9:0]  step;
	logic [14:0] t_nxt;
	logic [6:0]  k_nxt;
	logic        last_pose, issue, issue_last, pop;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	carry_t             c_s1, c_s2, c_s3, c_s4, c_s5;
	logic signed [31:0] stc_s1, sts_s1;
	logic [13:0]        t_s1;
	logic signed [46:0] px_s2, py_s2;
	logic [28:0]        ax_s3, ay_s3, ax_s4, ay_s4;
	logic               nx_s3, ny_s3, nx_s4, ny_s4;
	logic [22:0]        qx_s4, qy_s4;
	logic signed [31:0] ox_s5, oy_s5;

	assign en        = !vld_s5 || out_ready;
	assign step      = eff_step(cfg);
	assign t_nxt     = {1'b0, t_q} + 15'(step);
	assign k_nxt     = k_q + 7'd1;
	assign last_pose = (k_nxt >= 7'(MAX_POSES)) ||
		(({1'b0, t_nxt} + 16'(step)) > 16'(cfg.horizon_ms));
	assign issue      = act_q && en;
	assign issue_last = obj_q.no_pose || last_pose;
	assign pop_ready  = en && (!act_q || issue_last);
	assign pop        = pop_ready && pop_valid;

	// Object load and step counting; the next object loads on the last beat of this one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			k_q   <= '0;
			t_q   <= '0;
		end else if (en) begin
			if (pop) begin
				act_q <= 1'b1;
				k_q   <= '0;
				t_q   <= '0;
			end else if (act_q) begin
				if (issue_last) begin
					act_q <= 1'b0;
				end
				k_q <= k_nxt;
				t_q <= t_nxt[13:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			obj_q <= pop_data;
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stage 1: issued pose request.
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1.tag   <= obj_q.tag;
			c_s1.k     <= obj_q.no_pose ? 7'd0 : k_nxt;
			c_s1.has   <= !obj_q.no_pose;
			c_s1.last  <= issue_last;
			c_s1.pos_x <= obj_q.pos_x;
			c_s1.pos_y <= obj_q.pos_y;
			c_s1.pos_z <= obj_q.pos_z;
			stc_s1     <= obj_q.stc;
			sts_s1     <= obj_q.sts;
			t_s1       <= t_nxt[13:0];
		end
	end

	// Stage 2: speed * trig * time.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= stc_s1 * $signed({1'b0, t_s1});
			py_s2 <= sts_s1 * $signed({1'b0, t_s1});
			c_s2  <= c_s1;
		end
	end

	// Stage 3: magnitude plus rounding half, power-of-two part of the divisor.
	logic [46:0] mx_c, my_c;

	always_comb begin
		mx_c = (px_s2[46] ? 47'(-px_s2) : 47'(px_s2)) + ROUND_HALF;
		my_c = (py_s2[46] ? 47'(-py_s2) : 47'(py_s2)) + ROUND_HALF;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s3 <= mx_c[46:DIV_SHIFT];
			ay_s3 <= my_c[46:DIV_SHIFT];
			nx_s3 <= px_s2[46];
			ny_s3 <= py_s2[46];
			c_s3  <= c_s2;
		end
	end

	// Stage 4: quotient estimate by 125 through the reciprocal, at most one too large.
	logic [59:0] rx_c, ry_c;

	assign rx_c = ax_s3 * DIV_RECIP;
	assign ry_c = ay_s3 * DIV_RECIP;

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s4 <= rx_c[59:RECIP_SHIFT];
			qy_s4 <= ry_c[59:RECIP_SHIFT];
			ax_s4 <= ax_s3;
			ay_s4 <= ay_s3;
			nx_s4 <= nx_s3;
			ny_s4 <= ny_s3;
			c_s4  <= c_s3;
		end
	end

	// Stage 5: quotient correction, sign, add to the position and saturate.
	logic [29:0]        bx_c, by_c;
	logic [22:0]        fx_c, fy_c;
	logic signed [32:0] dx_c, dy_c;

	always_comb begin
		bx_c = qx_s4 * DIV_ODD;
		by_c = qy_s4 * DIV_ODD;
		fx_c = (bx_c > {1'b0, ax_s4}) ? qx_s4 - 23'd1 : qx_s4;
		fy_c = (by_c > {1'b0, ay_s4}) ? qy_s4 - 23'd1 : qy_s4;
		dx_c = nx_s4 ? -$signed({10'd0, fx_c}) : $signed({10'd0, fx_c});
		dy_c = ny_s4 ? -$signed({10'd0, fy_c}) : $signed({10'd0, fy_c});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s5 <= sat32($signed({c_s4.pos_x[31], c_s4.pos_x}) + dx_c);
			oy_s5 <= sat32($signed({c_s4.pos_y[31], c_s4.pos_y}) + dy_c);
			c_s5  <= c_s4;
		end
	end

	// Output beat; a marker beat carries zero pose fields.
	always_comb begin
		out_valid               = vld_s5;
		out_data.result_tag     = c_s5.tag;
		out_data.step_index     = c_s5.k;
		out_data.pose_x         = c_s5.has ? ox_s5 : '0;
		out_data.pose_y         = c_s5.has ? oy_s5 : '0;
		out_data.pose_z         = c_s5.has ? c_s5.pos_z : '0;
		out_data.has_pose       = c_s5.has;
		out_data.last_of_object = c_s5.last;
	end

`ifndef ASSERT_OFF
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && !c_s5.has) |-> (c_s5.last && c_s5.k == 7'd0))
		else $error("marker beat malformed");
	a_pose_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && c_s5.has) |-> (c_s5.k != 7'd0 && c_s5.k <= 7'(MAX_POSES)))
		else $error("pose index out of range");
	a_hold_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q && !en) |=> ($stable(k_q) && $stable(t_q)))
		else $error("sequencer moved while stalled");
`endif

endmodule

>>> sv/constant_velocity_pose_extrapolator.sv
`timescale 1ns / 1ps
// Top level of the constant-velocity pose extrapolator.
//
// Objects enter on in_valid/in_ready, one beat per tracked object. Each object
// yields a run of pose beats on out_valid/out_ready, one per step time up to
// the horizon and at most MAX_POSES, the final one marked last_of_object. A
// skipped object, or one whose step exceeds the horizon, yields a single beat
// with has_pose low. Registers are written on cfg_valid/cfg_ready, which is
// always ready; the user must write them only while no object is in flight,
// which the block itself does not enforce. The front end performs one CORDIC
// iteration per pipeline stage, and the queue sits between it and the pose
// pipeline. The output runs at one beat per cycle while the receiver does not
// stall, so an object with n poses yields n output beats (one for an object
// without poses); the front end accepts one object per cycle while the
// two-entry queue has room.
// Reset empties every pipeline stage and the queue and restores the register
// defaults. When the receiver stalls, the pose pipeline holds, the queue fills,
// and then in_ready drops.
module constant_velocity_pose_extrapolator
	import cvpe_pkg::*;
#(
	parameter int unsigned MAX_POSES         = 64,
	parameter int unsigned CORDIC_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  obj_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output pose_out_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg_q;
	logic q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
	obj_t q_push_data, q_pop_data;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_ms             <= STEP_RST;
			cfg_q.horizon_ms          <= HORIZON_RST;
			cfg_q.length_threshold_mm <= THRESH_RST;
			cfg_q.speed_large_mm_s    <= SPD_LRG_RST;
			cfg_q.speed_small_mm_s    <= SPD_SML_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STEP_MS: begin
					cfg_q.step_ms <= cfg_data[9:0];
				end
				REG_HORIZON_MS: begin
					cfg_q.horizon_ms <= cfg_data[13:0];
				end
				REG_LEN_THRESH: begin
					cfg_q.length_threshold_mm <= cfg_data;
				end
				REG_SPEED_LRG: begin
					cfg_q.speed_large_mm_s <= cfg_data;
				end
				REG_SPEED_SML: begin
					cfg_q.speed_small_mm_s <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	cvpe_front #(
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push_valid(q_push_valid),
		.push_ready(q_push_ready),
		.push_data (q_push_data)
	);

	cvpe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(q_push_valid),
		.push_ready(q_push_ready),
		.push_data (q_push_data),
		.pop_valid (q_pop_valid),
		.pop_ready (q_pop_ready),
		.pop_data  (q_pop_data)
	);

	cvpe_back #(
		.MAX_POSES(MAX_POSES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pop_valid(q_pop_valid),
		.pop_ready(q_pop_ready),
		.pop_data (q_pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
